// ===== design/lsf_pkg.sv =====
// Shared types, constants and helpers of the line substring filter.
`default_nettype none
package lsf_pkg;

	localparam int LINE_MAX_DEFAULT    = 1024;
	localparam int PATTERN_MAX_DEFAULT = 32;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int PAT_LEN_W   = 6;
	localparam int PAT_BYTES   = 32;
	localparam int PAT_REGS    = 4;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;
	localparam logic [7:0] CHAR_NUL     = 8'h00;

	localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAT_0_7   = 3'd0,
		REG_PAT_8_15  = 3'd1,
		REG_PAT_16_23 = 3'd2,
		REG_PAT_24_31 = 3'd3,
		REG_PAT_LEN   = 3'd4,
		REG_CASE_INS  = 3'd5,
		REG_INVERT    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_stream;
	} text_item_t;

	typedef struct packed {
		logic [31:0] line_number;
		logic        line_valid;
		logic        line_selected;
		logic [31:0] match_count;
		logic        stream_end;
	} result_item_t;

	// Settings seen by the scanner and the result stage.
	typedef struct packed {
		logic [PAT_LEN_W-1:0] eff_len;
		logic                 fold_en;
		logic                 invert;
	} cfg_ctrl_t;

	// What the scanner reports about the request at the input stage.
	typedef struct packed {
		logic ends_line;
		logic line_pending;
		logic found;
	} scan_status_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
			r = b + CASE_OFFSET;
		return r;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		logic [31:0] r;
		r = (v == COUNT_TOP) ? v : v + 32'd1;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/line_substring_filter_unit.sv =====
// Top level of the line substring filter: input stage, scanner, result stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  text     | text_valid / text_ready    | text_item  (text_byte, end_of_stream)
//  result   | result_valid / result_ready| result_item (line_number .. stream_end)
//  config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// One request per cycle is taken unless a line-ending request waits for the
// result slot; such a request is registered into result_item as it leaves
// the input stage. The loop through the byte window (shift plus parallel
// compare of all pattern slots) sets the rate.
// Reset clears the settings, line state and counters; the byte window holds
// no reset and is masked by its fill count. A stall on result_ready holds
// a line-ending request and all input behind it; other bytes keep flowing.
`default_nettype none
module line_substring_filter_unit import lsf_pkg::*; #(
	parameter int LINE_MAX    = LINE_MAX_DEFAULT,
	parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   text_valid,
	output logic                        text_ready,
	input  wire text_item_t             text_item,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output result_item_t                result_item,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_ctrl_t                   ctrl;
	logic [PATTERN_MAX-1:0][7:0] pat_aligned;
	logic [PATTERN_MAX-1:0]      pat_mask;
	scan_status_t                status;

	logic       valid_s1;
	text_item_t item_s1;
	logic       advance;
	logic       res_free;

	// Drain the input stage unless it ends a line and the result slot is full.
	assign advance    = valid_s1 && (!status.ends_line || res_free);
	assign text_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (text_ready)
			valid_s1 <= text_valid;
	end

	// Capture the request payload on acceptance.
	always_ff @(posedge clk) begin
		if (text_ready && text_valid)
			item_s1 <= text_item;
	end

	lsf_cfg_regs #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.ctrl       (ctrl),
		.pat_aligned(pat_aligned),
		.pat_mask   (pat_mask)
	);

	lsf_line_scan #(
		.LINE_MAX   (LINE_MAX),
		.PATTERN_MAX(PATTERN_MAX)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.ctrl       (ctrl),
		.pat_aligned(pat_aligned),
		.pat_mask   (pat_mask),
		.status     (status)
	);

	lsf_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.status   (status),
		.ctrl     (ctrl),
		.free     (res_free),
		.out_valid(result_valid),
		.out_ready(result_ready),
		.out_item (result_item)
	);

endmodule
`default_nettype wire

// ===== design/lsf_cfg_regs.sv =====
// Configuration registers and the pattern aligned to the byte window.
`default_nettype none
module lsf_cfg_regs import lsf_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,
	output cfg_ctrl_t                        ctrl,
	output logic [PATTERN_MAX-1:0][7:0]      pat_aligned,
	output logic [PATTERN_MAX-1:0]           pat_mask
);

	logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_regs_q;
	logic [PAT_LEN_W-1:0]                pat_len_q;
	logic                                case_ins_q;
	logic                                invert_q;
	logic [PAT_BYTES-1:0][7:0]           pat_bytes;
	logic [PAT_LEN_W-1:0]                eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_regs_q <= '0;
			pat_len_q  <= '0;
			case_ins_q <= 1'b0;
			invert_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_0_7:   pat_regs_q[0] <= cfg_data;
				REG_PAT_8_15:  pat_regs_q[1] <= cfg_data;
				REG_PAT_16_23: pat_regs_q[2] <= cfg_data;
				REG_PAT_24_31: pat_regs_q[3] <= cfg_data;
				REG_PAT_LEN:   pat_len_q     <= cfg_data[PAT_LEN_W-1:0];
				REG_CASE_INS:  case_ins_q    <= cfg_data[0];
				REG_INVERT:    invert_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pat_bytes = pat_regs_q;
	assign eff_len   = (pat_len_q > PAT_LEN_W'(PATTERN_MAX)) ?
			PAT_LEN_W'(PATTERN_MAX) : pat_len_q;

	assign ctrl.eff_len = eff_len;
	assign ctrl.fold_en = case_ins_q;
	assign ctrl.invert  = invert_q;

	// Window slot j (newest first) lines up with pattern byte eff_len-1-j.
	always_comb begin
		logic [4:0] idx;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			idx            = 5'(eff_len - PAT_LEN_W'(j) - PAT_LEN_W'(1));
			pat_mask[j]    = PAT_LEN_W'(j) < eff_len;
			pat_aligned[j] = fold_byte(pat_bytes[idx], case_ins_q);
		end
	end

endmodule
`default_nettype wire

// ===== design/lsf_line_scan.sv =====
// Per-line state: byte window, fill, zero-byte mark, line length and match flag.
`default_nettype none
module lsf_line_scan import lsf_pkg::*; #(
	parameter int LINE_MAX    = LINE_MAX_DEFAULT,
	parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire text_item_t                  item,
	input  wire cfg_ctrl_t                   ctrl,
	input  wire logic [PATTERN_MAX-1:0][7:0] pat_aligned,
	input  wire logic [PATTERN_MAX-1:0]      pat_mask,
	output scan_status_t                     status
);

	localparam int LEN_W  = $clog2(LINE_MAX);
	localparam int FILL_W = $clog2(PATTERN_MAX + 1);

	logic [PATTERN_MAX-1:0][7:0] win_q;
	logic [PATTERN_MAX-1:0][7:0] win_next;
	logic [FILL_W-1:0]           fill_q;
	logic [FILL_W-1:0]           fill_next;
	logic [LEN_W-1:0]            len_q;
	logic                        found_q;
	logic                        zero_q;
	logic                        line_full;
	logic                        hit_now;

	assign line_full = (len_q == LEN_W'(LINE_MAX - 1));

	assign status.ends_line    = item.end_of_stream || item.text_byte == CHAR_NEWLINE
			|| line_full;
	assign status.line_pending = (len_q != '0);
	assign status.found        = found_q;

	// Window as it would stand after taking this byte.
	always_comb begin
		win_next[0] = item.text_byte;
		for (int j = 1; j < PATTERN_MAX; j++)
			win_next[j] = win_q[j-1];
	end

	assign fill_next = (fill_q == FILL_W'(PATTERN_MAX)) ? fill_q : fill_q + FILL_W'(1);

	always_comb begin
		logic all_eq;
		all_eq = 1'b1;
		for (int j = 0; j < PATTERN_MAX; j++)
			if (pat_mask[j] && fold_byte(win_next[j], ctrl.fold_en) != pat_aligned[j])
				all_eq = 1'b0;
		hit_now = (ctrl.eff_len != '0) && (PAT_LEN_W'(fill_next) >= ctrl.eff_len) && all_eq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			len_q   <= '0;
			found_q <= 1'b0;
			zero_q  <= 1'b0;
		end else if (advance) begin
			if (status.ends_line) begin
				fill_q  <= '0;
				len_q   <= '0;
				found_q <= 1'b0;
				zero_q  <= 1'b0;
			end else begin
				len_q <= len_q + LEN_W'(1);
				if (item.text_byte == CHAR_NUL) begin
					zero_q <= 1'b1;
				end else if (!zero_q) begin
					fill_q <= fill_next;
					if (hit_now)
						found_q <= 1'b1;
				end
			end
		end
	end

	// Slots past the fill count never decide a match, so the window needs no reset.
	always_ff @(posedge clk) begin
		if (advance && !status.ends_line && item.text_byte != CHAR_NUL && !zero_q)
			win_q <= win_next;
	end

endmodule
`default_nettype wire

// ===== design/lsf_result.sv =====
// Line and match counters and the registered result stage.
`default_nettype none
module lsf_result import lsf_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,
	input  wire text_item_t   item,
	input  wire scan_status_t status,
	input  wire cfg_ctrl_t    ctrl,
	output logic              free,
	output logic              out_valid,
	input  wire logic         out_ready,
	output result_item_t      out_item
);

	logic [31:0]  lines_q;
	logic [31:0]  sel_q;
	logic         out_valid_s2;
	result_item_t out_item_s2;
	logic         hit;
	logic [31:0]  lines_next;
	logic [31:0]  sel_next;
	logic         emit;
	logic         finish;

	assign free      = !out_valid_s2 || out_ready;
	assign out_valid = out_valid_s2;
	assign out_item  = out_item_s2;

	assign emit       = advance && status.ends_line;
	// End of stream with nothing pending reports counters without a line.
	assign finish     = !item.end_of_stream || status.line_pending;
	assign hit        = ((ctrl.eff_len == '0) || status.found) ^ ctrl.invert;
	assign lines_next = sat_inc(lines_q);
	assign sel_next   = hit ? sat_inc(sel_q) : sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q      <= '0;
			sel_q        <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_s2 <= 1'b1;
				if (item.end_of_stream) begin
					lines_q <= '0;
					sel_q   <= '0;
				end else begin
					lines_q <= lines_next;
					sel_q   <= sel_next;
				end
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_s2.line_number   <= finish ? lines_next : lines_q;
			out_item_s2.line_valid    <= finish;
			out_item_s2.line_selected <= finish && hit;
			out_item_s2.match_count   <= finish ? sel_next : sel_q;
			out_item_s2.stream_end    <= item.end_of_stream;
		end
	end

endmodule
`default_nettype wire

// ===== design/lsf_checker.sv =====
// Port-level checks of the line substring filter and their binding.
`default_nettype none
module lsf_checker import lsf_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         result_valid,
	input wire logic         result_ready,
	input wire result_item_t result_item
);

	// Hold a stalled result unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("result changed while stalled");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.line_valid |->
			result_item.stream_end && !result_item.line_selected)
		else $error("result without a line is not a bare stream end");

	a_line_numbered: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.line_valid |-> result_item.line_number != 32'd0)
		else $error("finished line carries line number zero");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_item.match_count <= result_item.line_number)
		else $error("match count exceeds line count");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid right after reset");

endmodule

bind line_substring_filter_unit lsf_checker u_lsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result_item (result_item)
);
`default_nettype wire
